@@ src/landmark_distance_bound_engine_defines.svh @@
// Assertion macros for the landmark distance bound engine checker.
// No dependencies.
`ifndef LANDMARK_DISTANCE_BOUND_ENGINE_DEFINES_SVH
`define LANDMARK_DISTANCE_BOUND_ENGINE_DEFINES_SVH
// Implication checked on every clock, off while in reset.
`define LDBE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next, off while in reset.
`define LDBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ src/ldbe_pkg.sv @@
// Package for the landmark distance bound engine: widths, codes, payload types.
// No dependencies.
`default_nettype none
package ldbe_pkg;
	localparam int NumLm    = 16;
	localparam int LmBits   = $clog2(NumLm);
	localparam int VtxBits  = 12;
	localparam int DistBits = 31;
	localparam int AddrBits = LmBits + VtxBits;
	localparam int CfgBits  = LmBits + 1;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_SELECT = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [0:0] {
		CFG_LANDMARK_COUNT = 1'b0,
		CFG_ACTIVE_COUNT   = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_SORT,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]          opcode;
		logic [LmBits-1:0]   landmark_index;
		logic [VtxBits-1:0]  vertex_a;
		logic [VtxBits-1:0]  vertex_b;
		logic [DistBits-1:0] distance_value;
	} in_item_t;

	typedef struct packed {
		logic [DistBits-1:0] bound_value;
		logic [1:0]          item_kind;
	} out_item_t;
endpackage
`default_nettype wire

@@ src/ldbe_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module ldbe_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Write or read one entry a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

@@ src/ldbe_ctrl.sv @@
// Sequencer for the landmark distance bound engine: two banked table reads per
// landmark, select sort, active list fill and query max. Uses ldbe_pkg.
`default_nettype none
module ldbe_ctrl (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire ldbe_pkg::in_item_t                 item,
	input  wire logic [ldbe_pkg::CfgBits-1:0]       landmark_count,
	input  wire logic [ldbe_pkg::CfgBits-1:0]       active_count,
	output logic                                    busy,
	output logic                                    done,
	output ldbe_pkg::out_item_t                     result,
	output logic                                    tab_we,
	output logic [ldbe_pkg::AddrBits-1:0]           tab_addr,
	output logic [ldbe_pkg::DistBits-1:0]           tab_wdata,
	input  wire logic [ldbe_pkg::DistBits-1:0]      rd_a,
	input  wire logic [ldbe_pkg::DistBits-1:0]      rd_b
);
	import ldbe_pkg::*;

	state_t state_q, state_d;
	in_item_t item_q;
	logic [CfgBits-1:0] eff_l, eff_n;
	logic [CfgBits-1:0] cnt_q;
	logic [LmBits-1:0] lm_sel;
	logic [DistBits-1:0] gap;
	logic [DistBits-1:0] bound_q;
	logic [DistBits-1:0] score_q [NumLm];
	logic [LmBits-1:0] order_q [NumLm];
	logic [LmBits-1:0] act_q [NumLm];
	logic [CfgBits-1:0] last;
	logic [LmBits-1:0] pick_idx;

	// Clamp configuration where it is used
	always_comb begin
		eff_l = landmark_count;
		if (landmark_count == '0) eff_l = CfgBits'(1);
		else if (landmark_count > CfgBits'(NumLm)) eff_l = CfgBits'(NumLm);
		eff_n = active_count;
		if (active_count == '0) eff_n = CfgBits'(1);
		else if (active_count > eff_l) eff_n = eff_l;
	end

	// Query walks the active list, select walks landmarks in order
	assign lm_sel = (item_q.opcode == OP_QUERY) ? act_q[cnt_q[LmBits-1:0]] : cnt_q[LmBits-1:0];
	assign gap = (rd_a > rd_b) ? rd_a - rd_b : rd_b - rd_a;
	assign last = (item_q.opcode == OP_QUERY) ? eff_n : eff_l;

	// Table port shares both vertex reads: banked by the top level on vertex, two RAMs
	always_comb begin
		tab_we = 1'b0;
		tab_addr = {lm_sel, item_q.vertex_a};
		tab_wdata = item_q.distance_value;
		if (state_q == ST_IDLE) begin
			tab_we = start && (item.opcode == OP_LOAD);
			tab_addr = {item.landmark_index, item.vertex_a};
			tab_wdata = item.distance_value;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start) begin
				if (item.opcode == OP_SELECT || item.opcode == OP_QUERY) state_d = ST_READ;
				else state_d = ST_DONE;
			end
			ST_READ: state_d = ST_WAIT;
			ST_WAIT: state_d = ST_SORT;
			ST_SORT: begin
				if (cnt_q + CfgBits'(1) < last) state_d = ST_READ;
				else if (item_q.opcode == OP_SELECT) state_d = ST_FILL;
				else state_d = ST_DONE;
			end
			ST_FILL: if (cnt_q + CfgBits'(1) >= eff_n) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_DONE);
		result.item_kind = item_q.opcode;
		result.bound_value = (item_q.opcode == OP_QUERY) ? bound_q : '0;
	end

	// Alternate picks from the top and bottom of the order
	always_comb begin
		if (!cnt_q[0]) pick_idx = cnt_q[LmBits:1];
		else pick_idx = LmBits'(eff_l - CfgBits'(1) - CfgBits'(cnt_q[CfgBits-1:1]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			for (int i = 0; i < NumLm; i++) act_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE || (state_q == ST_SORT && state_d != ST_READ)) begin
				cnt_q <= '0;
			end else if (state_q == ST_SORT || state_q == ST_FILL) begin
				cnt_q <= cnt_q + CfgBits'(1);
			end
			if (state_q == ST_FILL) act_q[cnt_q[LmBits-1:0]] <= order_q[pick_idx];
		end
	end

	// Payload: capture item, accumulate max, insert into sorted order
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			item_q <= item;
			bound_q <= '0;
		end
		if (state_q == ST_SORT) begin
			if (gap > bound_q) bound_q <= gap;
			// Landmark index cnt always beats equal scores already placed
			for (int j = 0; j < NumLm; j++) begin
				if (CfgBits'(j) <= cnt_q) begin
					if (CfgBits'(j) == cnt_q) begin
						if (j == 0 || score_q[(j == 0) ? 0 : j-1] > gap) begin
							score_q[j] <= gap;
							order_q[j] <= cnt_q[LmBits-1:0];
						end else begin
							score_q[j] <= score_q[j-1];
							order_q[j] <= order_q[j-1];
						end
					end else if (score_q[j] <= gap) begin
						if (j == 0 || score_q[(j == 0) ? 0 : j-1] > gap) begin
							score_q[j] <= gap;
							order_q[j] <= cnt_q[LmBits-1:0];
						end else begin
							score_q[j] <= score_q[j-1];
							order_q[j] <= order_q[j-1];
						end
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ src/landmark_distance_bound_engine.sv @@
// Landmark (ALT) distance bound engine top level: config registers, table RAMs,
// sequencer. Uses ldbe_pkg, ldbe_ram, ldbe_ctrl.
//
// One item at a time, signalled by start while busy is low; each item gives one
// result on done for a single cycle, which the receiver must take. A select or
// query reads one table pair per landmark (query: per active one) through the
// distance RAMs. The table is two copies of a 64K x 31 RAM so both vertices of
// a pair read in the same cycle.
`default_nettype none
module landmark_distance_bound_engine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire ldbe_pkg::in_item_t            item,
	output logic                               busy,
	output logic                               done,
	output ldbe_pkg::out_item_t                result,
	input  wire logic                          cfg_we,
	input  wire logic [0:0]                    cfg_index,
	input  wire logic [ldbe_pkg::CfgBits-1:0]  cfg_data
);
	import ldbe_pkg::*;

	logic [CfgBits-1:0] landmark_count_q, active_count_q;
	logic tab_we;
	logic [AddrBits-1:0] tab_addr, addr_a, addr_b;
	logic [DistBits-1:0] tab_wdata, rd_a, rd_b;
	logic [VtxBits-1:0] vb_sel;
	logic [VtxBits-1:0] item_b_q;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			landmark_count_q <= CfgBits'(16);
			active_count_q <= CfgBits'(8);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LANDMARK_COUNT: landmark_count_q <= cfg_data;
				CFG_ACTIVE_COUNT:   active_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ldbe_ctrl u_ctrl (
		.clk, .arst_n, .start, .item,
		.landmark_count(landmark_count_q),
		.active_count(active_count_q),
		.busy, .done, .result,
		.tab_we, .tab_addr, .tab_wdata, .rd_a, .rd_b
	);

	// Copy B reads the second vertex of the accepted item, held here while busy
	assign vb_sel = busy ? item_b_q : item.vertex_b;
	assign addr_a = tab_addr;
	assign addr_b = tab_we ? tab_addr : {tab_addr[AddrBits-1:VtxBits], vb_sel};

	always_ff @(posedge clk) begin
		if (start && !busy) item_b_q <= item.vertex_b;
	end

	ldbe_ram #(.Width(DistBits), .Depth(1 << AddrBits)) u_tab_a (
		.clk, .we(tab_we), .addr(addr_a), .wdata(tab_wdata), .rdata(rd_a)
	);
	ldbe_ram #(.Width(DistBits), .Depth(1 << AddrBits)) u_tab_b (
		.clk, .we(tab_we), .addr(addr_b), .wdata(tab_wdata), .rdata(rd_b)
	);
endmodule
`default_nettype wire

@@ src/ldbe_checker.sv @@
// Port-level checker for the landmark distance bound engine, with its bind.
// Uses ldbe_pkg and landmark_distance_bound_engine_defines.svh.
`include "landmark_distance_bound_engine_defines.svh"
`default_nettype none
module ldbe_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire ldbe_pkg::out_item_t result
);
	import ldbe_pkg::*;

	// An accepted item makes the block busy
	`LDBE_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "accepted item not busy")
	// A result ends the item
	`LDBE_ASSERT_NEXT(a_done_idle, clk, arst_n, done, !busy, "busy after result")
	// A result is a single cycle
	`LDBE_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "result longer than a cycle")
	// Only a query transfers a nonzero bound
	`LDBE_ASSERT(a_bound_zero, clk, arst_n, (done && result.item_kind != OP_QUERY) |-> (result.bound_value == '0), "stray bound")
endmodule

bind landmark_distance_bound_engine ldbe_checker u_ldbe_checker (
	.clk, .arst_n, .start, .busy, .done, .result
);
`default_nettype wire

@@ tb/tb.sv @@
// Testbench for landmark_distance_bound_engine: directed table, then random transfers
// checked against an in-bench bound predictor. Depends on ldbe_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import ldbe_pkg::*;

	typedef struct {
		in_item_t  cmd;
		bit        typed;
		out_item_t answer;
	} step_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	in_item_t            item;
	logic                busy;
	logic                done;
	out_item_t           result;
	logic                cfg_we;
	logic [0:0]          cfg_index;
	logic [CfgBits-1:0]  cfg_data;

	// shadow state of the engine
	bit [DistBits-1:0]   dist_mem [NumLm][1 << VtxBits];
	bit [LmBits-1:0]     picked [NumLm];
	bit [CfgBits-1:0]    lm_reg;
	bit [CfgBits-1:0]    act_reg;

	out_item_t           pending_q [$];
	bit [VtxBits-1:0]    pool [8];
	int                  mismatches;
	int                  idle_pct;

	landmark_distance_bound_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int lm_in_use();
		if (lm_reg == 0) return 1;
		if (lm_reg > NumLm) return NumLm;
		return int'(lm_reg);
	endfunction

	function automatic int act_in_use();
		int l;
		l = lm_in_use();
		if (act_reg == 0) return 1;
		if (act_reg > l) return l;
		return int'(act_reg);
	endfunction

	function automatic bit [DistBits-1:0] dist_gap(int lm, bit [VtxBits-1:0] a,
			bit [VtxBits-1:0] b);
		bit [DistBits-1:0] x;
		bit [DistBits-1:0] y;
		x = dist_mem[lm][a];
		y = dist_mem[lm][b];
		return (x > y) ? x - y : y - x;
	endfunction

	// Apply one transfer to the shadow state and return the bound it yields.
	function automatic out_item_t bound_predict(in_item_t it);
		out_item_t         r;
		bit [DistBits-1:0] sc [NumLm];
		int                ord [NumLm];
		bit [DistBits-1:0] s;
		int                l;
		int                n;
		int                j;
		r.bound_value = '0;
		r.item_kind   = it.opcode;
		l = lm_in_use();
		n = act_in_use();
		case (it.opcode)
			OP_LOAD: begin
				dist_mem[it.landmark_index][it.vertex_a] = it.distance_value;
			end
			OP_SELECT: begin
				// rank by score, larger first, higher landmark wins a tie
				for (int i = 0; i < l; i++) begin
					s = dist_gap(i, it.vertex_a, it.vertex_b);
					j = i;
					while (j > 0 && (sc[j-1] < s || (sc[j-1] == s && ord[j-1] < i))) begin
						sc[j]  = sc[j-1];
						ord[j] = ord[j-1];
						j--;
					end
					sc[j]  = s;
					ord[j] = i;
				end
				// alternate picks from the head and the tail of the ranking
				for (int i = 0; i < n; i++)
					picked[i] = LmBits'((i % 2 == 0) ? ord[i/2] : ord[l - 1 - i/2]);
			end
			OP_QUERY: begin
				for (int i = 0; i < n; i++) begin
					s = dist_gap(picked[i], it.vertex_a, it.vertex_b);
					if (s > r.bound_value) r.bound_value = s;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Drive one transfer, optionally idling first; returns after acceptance.
	task automatic send_cmd(in_item_t it, bit typed, out_item_t answer);
		out_item_t exp_r;
		if ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		exp_r = bound_predict(it);
		pending_q.insert(pending_q.size(), typed ? answer : exp_r);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_q.size() != 0 || busy) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, bit [CfgBits-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == CFG_LANDMARK_COUNT) lm_reg = val;
		else act_reg = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic in_item_t make_cmd(opcode_t op, int lm, int a, int b, int d);
		in_item_t it;
		it.opcode         = op;
		it.landmark_index = LmBits'(lm);
		it.vertex_a       = VtxBits'(a);
		it.vertex_b       = VtxBits'(b);
		it.distance_value = DistBits'(d);
		return it;
	endfunction

	function automatic bit [DistBits-1:0] rand_dist();
		case ($urandom_range(0, 3))
			0: return DistBits'($urandom_range(0, 3));
			1: return {DistBits{1'b1}};
			default: return DistBits'($urandom);
		endcase
	endfunction

	// Build one random transfer; reads only touch fully loaded pool vertices.
	function automatic in_item_t rand_cmd();
		int k;
		k = $urandom_range(0, 99);
		if (k < 25)
			return make_cmd(OP_LOAD, $urandom_range(0, 15), pool[$urandom_range(0, 7)], 0,
				rand_dist());
		if (k < 35)
			return make_cmd(OP_LOAD, $urandom_range(0, 15), $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom);
		if (k < 55)
			return make_cmd(OP_SELECT, $urandom_range(0, 15), pool[$urandom_range(0, 7)],
				pool[$urandom_range(0, 7)], $urandom);
		if (k < 95)
			return make_cmd(OP_QUERY, $urandom_range(0, 15), pool[$urandom_range(0, 7)],
				pool[$urandom_range(0, 7)], $urandom);
		return make_cmd(OP_NONE, $urandom_range(0, 15), $urandom_range(0, 4095),
			$urandom_range(0, 4095), $urandom);
	endfunction

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result bound=%0d kind=%0d",
						result.bound_value, result.item_kind);
			end else begin
				if (result.bound_value !== pending_q[0].bound_value ||
						result.item_kind !== pending_q[0].item_kind) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected bound=%0d kind=%0d, got bound=%0d kind=%0d",
							pending_q[0].bound_value, pending_q[0].item_kind,
							result.bound_value, result.item_kind);
				end
				void'(pending_q.pop_front());
			end
		end
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		step_row_t         rows [15];
		out_item_t         none_r;
		bit [CfgBits-1:0]  lm_set [8];
		bit [CfgBits-1:0]  act_set [8];
		int                per_phase;

		clk        = 1'b0;
		arst_n     = 1'b0;
		start      = 1'b0;
		item       = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		mismatches = 0;
		idle_pct   = 31;
		lm_reg     = 16;
		act_reg    = 8;
		foreach (picked[i]) picked[i] = '0;
		none_r     = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill a small vertex pool in every landmark row
		pool[0] = 0;
		pool[1] = 4095;
		for (int i = 2; i < 8; i++) pool[i] = VtxBits'($urandom_range(1, 4094));
		for (int lm = 0; lm < NumLm; lm++)
			foreach (pool[p])
				send_cmd(make_cmd(OP_LOAD, lm, pool[p], $urandom, rand_dist()), 1'b0, none_r);

		// directed rows; the active list is still all landmark zero here
		rows[0]  = '{make_cmd(OP_LOAD, 0, 0, 4095, 0), 1, '{0, OP_LOAD}};
		rows[1]  = '{make_cmd(OP_LOAD, 0, 4095, 0, 32'h7fffffff), 1, '{0, OP_LOAD}};
		rows[2]  = '{make_cmd(OP_QUERY, 15, 0, 4095, 0), 1, '{31'h7fffffff, OP_QUERY}};
		rows[3]  = '{make_cmd(OP_QUERY, 0, 4095, 0, 0), 1, '{31'h7fffffff, OP_QUERY}};
		rows[4]  = '{make_cmd(OP_QUERY, 0, 4095, 4095, 0), 1, '{0, OP_QUERY}};
		rows[5]  = '{make_cmd(OP_NONE, 15, 4095, 4095, 32'h7fffffff), 1, '{0, OP_NONE}};
		rows[6]  = '{make_cmd(OP_NONE, 0, 0, 0, 0), 1, '{0, OP_NONE}};
		rows[7]  = '{make_cmd(OP_LOAD, 15, 4095, 4095, 32'h7fffffff), 1, '{0, OP_LOAD}};
		rows[8]  = '{make_cmd(OP_LOAD, 15, 0, 0, 0), 1, '{0, OP_LOAD}};
		rows[9]  = '{make_cmd(OP_SELECT, 0, 0, 4095, 0), 0, none_r};
		rows[10] = '{make_cmd(OP_QUERY, 0, 0, 4095, 0), 0, none_r};
		rows[11] = '{make_cmd(OP_SELECT, 0, pool[2], pool[2], 0), 0, none_r};
		rows[12] = '{make_cmd(OP_QUERY, 0, pool[3], pool[4], 0), 0, none_r};
		rows[13] = '{make_cmd(OP_SELECT, 0, pool[5], pool[6], 0), 0, none_r};
		rows[14] = '{make_cmd(OP_QUERY, 0, pool[7], 0, 0), 0, none_r};
		foreach (rows[r]) send_cmd(rows[r].cmd, rows[r].typed, rows[r].answer);
		drain();

		// register settings per phase, extremes and out-of-range values included
		lm_set  = '{16, 1, 0, 31, 16, 5, 3, 17};
		act_set = '{8, 1, 0, 31, 16, 17, 2, 1};
		per_phase = 250;
		foreach (lm_set[p]) begin
			write_reg(CFG_LANDMARK_COUNT, lm_set[p]);
			write_reg(CFG_ACTIVE_COUNT, act_set[p]);
			for (int i = 0; i < per_phase; i++) begin
				// sender idling: light, then heavy, then none
				if (p < 3) idle_pct = 31;
				else if (p < 6) idle_pct = 59;
				else idle_pct = 0;
				send_cmd(rand_cmd(), 1'b0, none_r);
			end
			drain();
		end

		repeat (100) @(posedge clk);
		if (pending_q.size() != 0) mismatches++;
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
